[rtl/aenc_pkg.sv]
`timescale 1ns / 1ps
package aenc_pkg;

    localparam int CODE_BITS    = 32;
    localparam int TOTAL_BITS   = 17;
    localparam int LOW_BITS     = 16;
    localparam int PENDING_BITS = 16;
    localparam int FOLLOW_BITS  = 16;
    localparam int SPAN_BITS    = CODE_BITS + 1;
    localparam int PROD_BITS    = SPAN_BITS + TOTAL_BITS;
    localparam int ITER_BITS    = $clog2(CODE_BITS + 1);
    localparam int STEP_BITS    = $clog2(SPAN_BITS + 2);

    localparam logic [CODE_BITS-1:0]    QUARTER_MARK = CODE_BITS'(1) << (CODE_BITS - 2);
    localparam logic [PENDING_BITS-1:0] PEND_MAX     = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO_START,
        ST_LO_WAIT,
        ST_HI_START,
        ST_HI_WAIT,
        ST_RENORM,
        ST_FLUSH
    } enc_state_t;

endpackage

[rtl/arithmetic_encoder_core.sv]
`timescale 1ns / 1ps
// sequence: accept, two passes through the shared multiply-divide unit (low then high bound),
// then one renormalization step per cycle unless the output stalls (up to 32), one closing
// check and a flush; a new symbol is accepted only once the previous one is back in idle
// an empty symbol interval is accepted and yields no transaction
// reset (aresetn low, synchronous): interval to full range, pending count to zero,
// total count to 1, output channel empty
module arithmetic_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cum_low[15:0], cum_high[32:16], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // lead_bit[0], follow_count[16:1], zero fill
    output logic        m_tlast
);
    import aenc_pkg::*;

    enc_state_t state_reg, state_next;

    logic [TOTAL_BITS-1:0]   total_reg;
    logic [TOTAL_BITS-1:0]   tot_reg;
    logic [TOTAL_BITS-1:0]   cl_reg;
    logic [TOTAL_BITS-1:0]   ch_reg;
    logic [CODE_BITS-1:0]    low_reg;
    logic [CODE_BITS-1:0]    high_reg;
    logic [PENDING_BITS-1:0] pend_reg;
    logic [SPAN_BITS-1:0]    qlo_reg;
    logic [ITER_BITS-1:0]    iter_reg;
    logic                    held_valid_reg;
    logic                    held_bit_reg;
    logic [FOLLOW_BITS-1:0]  held_follow_reg;
    logic                    m_tvalid_reg;
    logic                    m_bit_reg;
    logic [FOLLOW_BITS-1:0]  m_follow_reg;
    logic                    m_last_reg;

    logic [TOTAL_BITS-1:0]   t_eff;
    logic [TOTAL_BITS-1:0]   ch_in;
    logic [TOTAL_BITS-1:0]   cl_raw;
    logic [TOTAL_BITS-1:0]   cl_in;
    logic                    has_work;
    logic                    in_take;
    logic [SPAN_BITS-1:0]    span;
    logic                    md_start;
    logic                    md_done;
    logic [SPAN_BITS-1:0]    md_quot;
    logic [SPAN_BITS:0]      nl_sum;
    logic [SPAN_BITS:0]      nh_sum;
    logic                    out_free;
    logic                    emit;
    logic                    emit_bit;
    logic                    straddle;
    logic                    renorm_end;
    logic                    push;
    logic                    push_last;

    // clamp the incoming interval against the total
    assign t_eff    = (total_reg == '0) ? TOTAL_BITS'(1) : total_reg;
    assign cl_raw   = {1'b0, s_tdata[15:0]};
    assign ch_in    = (s_tdata[32:16] > t_eff) ? t_eff : s_tdata[32:16];
    assign cl_in    = (cl_raw > ch_in) ? ch_in : cl_raw;
    assign has_work = cl_in < ch_in;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;

    // shared multiply-divide unit
    assign span     = SPAN_BITS'({1'b0, high_reg} - {1'b0, low_reg} + 1'b1);
    assign md_start = (state_reg == ST_LO_START) || (state_reg == ST_HI_START);

    aenc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .span    (span),
        .factor  ((state_reg == ST_LO_START) ? cl_reg : ch_reg),
        .divisor (tot_reg),
        .done    (md_done),
        .quot    (md_quot)
    );

    assign nl_sum = {2'b00, low_reg} + {1'b0, qlo_reg};
    assign nh_sum = {2'b00, low_reg} + {1'b0, md_quot};

    // renormalization decision for one step
    assign out_free   = !m_tvalid_reg || m_tready;
    assign emit       = !high_reg[CODE_BITS-1] || low_reg[CODE_BITS-1];
    assign emit_bit   = low_reg[CODE_BITS-1];
    assign straddle   = low_reg[CODE_BITS-2] && !high_reg[CODE_BITS-2];
    assign renorm_end = (iter_reg == ITER_BITS'(CODE_BITS)) || (!emit && !straddle);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_take && has_work) state_next = ST_LO_START;
            ST_LO_START: state_next = ST_LO_WAIT;
            ST_LO_WAIT:  if (md_done) state_next = ST_HI_START;
            ST_HI_START: state_next = ST_HI_WAIT;
            ST_HI_WAIT:  if (md_done) state_next = ST_RENORM;
            ST_RENORM:   if (renorm_end) state_next = ST_FLUSH;
            ST_FLUSH:    if (!held_valid_reg || out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // output push requests
    always_comb begin
        push      = 1'b0;
        push_last = 1'b0;
        unique case (state_reg)
            ST_RENORM: push = !renorm_end && emit && held_valid_reg && out_free;
            ST_FLUSH: begin
                push      = held_valid_reg && out_free;
                push_last = 1'b1;
            end
            default: push = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            total_reg      <= TOTAL_BITS'(1);
            low_reg        <= '0;
            high_reg       <= '1;
            pend_reg       <= '0;
            held_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                total_reg <= cfg_wdata;
            end
            if (push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_HI_WAIT: if (md_done) begin
                    low_reg  <= nl_sum[CODE_BITS-1:0];
                    high_reg <= (nh_sum > nl_sum) ? CODE_BITS'(nh_sum - 1'b1)
                                                  : nl_sum[CODE_BITS-1:0];
                end
                ST_RENORM: if (!renorm_end) begin
                    if (emit) begin
                        if (!held_valid_reg || out_free) begin
                            held_valid_reg <= 1'b1;
                            pend_reg       <= '0;
                            low_reg        <= low_reg << 1;
                            high_reg       <= {high_reg[CODE_BITS-2:0], 1'b1};
                        end
                    end else begin
                        if (pend_reg != PEND_MAX) pend_reg <= pend_reg + 1'b1;
                        low_reg  <= (low_reg - QUARTER_MARK) << 1;
                        high_reg <= {high_reg[CODE_BITS-2:0] - QUARTER_MARK[CODE_BITS-2:0],
                                     1'b1};
                    end
                end
                ST_FLUSH: if (out_free) held_valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            tot_reg  <= t_eff;
            cl_reg   <= cl_in;
            ch_reg   <= ch_in;
            iter_reg <= '0;
        end
        if (state_reg == ST_LO_WAIT && md_done) begin
            qlo_reg <= md_quot;
        end
        if (state_reg == ST_RENORM && !renorm_end &&
            (!emit || !held_valid_reg || out_free)) begin
            iter_reg <= iter_reg + 1'b1;
            if (emit) begin
                held_bit_reg    <= emit_bit;
                held_follow_reg <= FOLLOW_BITS'(pend_reg);
            end
        end
        if (push) begin
            m_bit_reg    <= held_bit_reg;
            m_follow_reg <= held_follow_reg;
            m_last_reg   <= push_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_follow_reg, m_bit_reg};
    assign m_tlast  = m_last_reg;

    // checks on the interval and sequencing
    a_interval_order: assert property (@(posedge aclk) disable iff (!aresetn)
        high_reg >= low_reg) else $error("interval high below low");
    a_idle_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !held_valid_reg) else $error("held result left at idle");
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> (state_reg == ST_LO_WAIT || state_reg == ST_HI_WAIT))
        else $error("divider done outside wait");

endmodule

[rtl/aenc_muldiv.sv]
`timescale 1ns / 1ps
module aenc_muldiv (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [aenc_pkg::SPAN_BITS-1:0]       span,
    input  logic [aenc_pkg::TOTAL_BITS-1:0]      factor,
    input  logic [aenc_pkg::TOTAL_BITS-1:0]      divisor,
    output logic                                 done,
    output logic [aenc_pkg::SPAN_BITS-1:0]       quot
);
    import aenc_pkg::*;

    logic [PROD_BITS-1:0]  prod_reg;
    logic [TOTAL_BITS-1:0] rem_reg;
    logic [SPAN_BITS-1:0]  quot_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic                  done_reg;
    logic [TOTAL_BITS:0]   rem_try;
    logic                  fits;

    // one restoring division step per cycle
    assign rem_try = {rem_reg, prod_reg[SPAN_BITS-1]};
    assign fits    = rem_try >= {1'b0, divisor};

    // step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                step_reg <= STEP_BITS'(SPAN_BITS + 1);
            end else if (step_reg != '0) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product, remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= PROD_BITS'(span) * PROD_BITS'(factor);
            quot_reg <= '0;
        end else if (step_reg == STEP_BITS'(SPAN_BITS + 1)) begin
            rem_reg <= prod_reg[PROD_BITS-1:SPAN_BITS];
        end else if (step_reg != '0) begin
            rem_reg  <= fits ? TOTAL_BITS'(rem_try - {1'b0, divisor})
                             : TOTAL_BITS'(rem_try);
            prod_reg <= prod_reg << 1;
            quot_reg <= {quot_reg[SPAN_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[verif/aenc_checker.sv]
`timescale 1ns / 1ps
module aenc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          err_count,
    output int          bits_owed
);
    import aenc_pkg::*;

    typedef struct packed {
        logic                   lead;
        logic [FOLLOW_BITS-1:0] follow;
        logic                   last;
    } code_bit_t;

    localparam longint unsigned HALF = 64'h8000_0000;
    localparam longint unsigned QTR  = 64'h4000_0000;
    localparam longint unsigned MASK = 64'hFFFF_FFFF;

    code_bit_t              owed_bits[$];
    longint unsigned        iv_low, iv_high;
    logic [PENDING_BITS-1:0] straddles;
    logic [TOTAL_BITS-1:0]  divider;

    assign bits_owed = owed_bits.size();

    // add one emitted bit, with the straddle count as its follow count
    function automatic void emit_bit(logic b);
        code_bit_t e;
        e.lead   = b;
        e.follow = straddles;
        e.last   = 1'b0;
        owed_bits.insert(owed_bits.size(), e);
        straddles = '0;
    endfunction

    // narrow the interval for one symbol and renormalize
    function automatic void encode_symbol(logic [15:0] cl_in, logic [16:0] ch_in);
        longint unsigned t, cl, ch, span, nl, nh;
        int emitted;
        t  = (divider == 0) ? 1 : divider;
        ch = ch_in;
        cl = cl_in;
        emitted = 0;
        if (ch > t) ch = t;
        if (cl > ch) cl = ch;
        if (cl >= ch) return;
        span = iv_high - iv_low + 1;
        nl = iv_low + (span * cl) / t;
        nh = iv_low + (span * ch) / t;
        nh = (nh > nl) ? nh - 1 : nl;
        iv_low  = nl & MASK;
        iv_high = nh & MASK;
        for (int i = 0; i < CODE_BITS; i++) begin
            if (iv_high < HALF) begin
                if (emitted < 32) begin emit_bit(1'b0); emitted++; end
            end else if (iv_low >= HALF) begin
                if (emitted < 32) begin emit_bit(1'b1); emitted++; end
            end else if (iv_low >= QTR && iv_high < HALF + QTR) begin
                if (straddles != PEND_MAX) straddles++;
                iv_low  -= QTR;
                iv_high -= QTR;
            end else begin
                break;
            end
            iv_low  = (iv_low << 1) & MASK;
            iv_high = ((iv_high << 1) | 1) & MASK;
        end
        if (emitted > 0) begin
            owed_bits[owed_bits.size() - 1].last = 1'b1;
        end
    endfunction

    // watch both channels and the register port
    always @(posedge aclk) begin
        code_bit_t want;
        if (!aresetn) begin
            iv_low    = 0;
            iv_high   = MASK;
            straddles = '0;
            divider   = 17'd1;
            owed_bits.delete();
            err_count = 0;
        end else begin
            if (cfg_we) divider = cfg_wdata;
            if (s_tvalid && s_tready) encode_symbol(s_tdata[15:0], s_tdata[32:16]);
            if (m_tvalid && m_tready) begin
                if (owed_bits.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected output transaction: data %h last %b",
                                 m_tdata, m_tlast);
                end else begin
                    want = owed_bits.pop_front();
                    if (m_tdata[0] !== want.lead || m_tdata[16:1] !== want.follow ||
                        m_tlast !== want.last || m_tdata[23:17] !== '0) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"mismatch: expected bit %b follow %0d last %b,",
                                      " got bit %b follow %0d last %b"},
                                     want.lead, want.follow, want.last,
                                     m_tdata[0], m_tdata[16:1], m_tlast);
                    end
                end
            end
        end
    end

endmodule

[verif/tb_arithmetic_encoder_core.sv]
`timescale 1ns / 1ps
module tb_arithmetic_encoder_core;
    import aenc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    int          err_count;
    int          bits_owed;
    int          burst_left = 0;
    int          quiet_cycles = 0;
    bit          hold_req = 1'b0;
    logic [16:0] cur_total = 17'd1;

    localparam int QUIET_LIMIT = 6000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    arithmetic_encoder_core u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    aenc_checker u_chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .err_count(err_count), .bits_owed(bits_owed)
    );

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls alternating with always-ready stretches, plus a long hold-off
    initial begin
        int tick;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (800) @(negedge aclk);
                hold_req = 1'b0;
            end
            tick++;
            if ((tick / 300) % 2 == 0)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= 1'b1;
        end
    end

    // one symbol transaction, sender in bursts with random gaps
    task automatic send_symbol(logic [15:0] cl, logic [16:0] ch);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tdata  <= {7'b0, ch, cl};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // write the divider once the block has drained
    task automatic set_total(logic [16:0] value);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (bits_owed != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_total = value;
    endtask

    // mostly well-formed symbols, some noise across all field bits
    task automatic random_symbols(int count);
        logic [16:0] t, ch;
        logic [15:0] cl;
        for (int i = 0; i < count; i++) begin
            t = (cur_total == 0) ? 17'd1 : cur_total;
            if ($urandom_range(0, 9) == 0) begin
                send_symbol(16'($urandom), 17'($urandom));
            end else begin
                ch = 17'($urandom_range(1, (t > 65536) ? 65536 : t));
                cl = 16'($urandom_range(0, ch - 1));
                send_symbol(cl, ch);
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset divider of one: whole interval, clamping, empty symbols
        send_symbol(16'd0, 17'd1);
        send_symbol(16'd1, 17'd1);
        send_symbol(16'hFFFF, 17'h1FFFF);

        // wide divider: extremes and narrow symbols
        set_total(17'd65536);
        send_symbol(16'd0, 17'd65536);
        send_symbol(16'd65535, 17'd65536);
        send_symbol(16'd0, 17'd1);
        send_symbol(16'd32768, 17'd32769);
        send_symbol(16'd40000, 17'd30000);
        send_symbol(16'd5, 17'd5);
        send_symbol(16'd0, 17'h1FFFF);
        send_symbol(16'd65535, 17'h1FFFF);
        send_symbol(16'd21845, 17'd43690);
        send_symbol(16'd16384, 17'd49152);

        // zero divider behaves as one
        set_total(17'd0);
        send_symbol(16'd0, 17'd1);
        send_symbol(16'd0, 17'd2);

        // largest divider, middle symbols build straddle counts
        set_total(17'h1FFFF);
        send_symbol(16'd0, 17'd1);
        send_symbol(16'd40000, 17'd90000);
        random_symbols(15);

        // small divider with a long receiver hold-off so the block backs up
        set_total(17'd4);
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_symbol(16'd1, 17'd3);
            send_symbol(16'd0, 17'd1);
        end
        random_symbols(14);

        set_total(17'd3);
        random_symbols(20);
        set_total(17'd1000);
        random_symbols(20);
        set_total(17'($urandom_range(1, 65536)));
        random_symbols(20);

        s_tvalid <= 1'b0;
        while (bits_owed != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
